// ===== rtl/max_heap_priority_queue_defines.svh =====
// Assertion macros for the max-heap priority queue checker.
// No dependencies; included by the checker file only.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mhpq assertion failed");

// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mhpq assertion failed");

`endif

// ===== rtl/mhpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue.
// No dependencies; used by the interfaces, the top level and the checker.
package mhpq_pkg;

  localparam int MHPQ_CAPACITY = 64;
  localparam int COUNT_W       = 7;
  localparam int VALUE_W       = 32;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } mhpq_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } mhpq_out_t;

endpackage

// ===== rtl/mhpq_in_if.sv =====
// Input channel of the max-heap priority queue: valid/ready plus one operation.
// Depends on mhpq_pkg.
interface mhpq_in_if import mhpq_pkg::*; ();
  logic     valid;
  logic     ready;
  mhpq_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mhpq_out_if.sv =====
// Result channel of the max-heap priority queue: valid/ready plus one result.
// Depends on mhpq_pkg.
interface mhpq_out_if import mhpq_pkg::*; ();
  logic      valid;
  logic      ready;
  mhpq_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue held in a one-write, two-read synchronous memory.
// Depends on mhpq_pkg, mhpq_in_if and mhpq_out_if.
//
//  channel | dir | transfer moves                         | when
//  --------+-----+----------------------------------------+---------------------------
//  in_i    | in  | mode, value (push or pop)              | valid & ready, idle only
//  out_o   | out | status, removed, top, count, is_empty  | valid & ready, registered
//
// A push climbs one level per compare step, the write of each level overlapping the
// read of the next parent. A pop fetches the last entry, then descends one level per read
// step and compare and write step, and ends with a compare and write step when it stops at
// an entry that still has children. The registered memory read ports set this sequence.
// Refused operations, pushes into an empty queue and pops that empty it go straight to S_DONE.
// Reset clears only control state and the count; the memory needs no clearing.
// A waiting result stalls only the final state (S_DONE) of the next operation.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = MHPQ_CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mhpq_in_if.sink      in_i,
  mhpq_out_if.source   out_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PU_CMP  = 3'd1;  // sift-up compare against parent
  localparam logic [2:0] S_PU_FIN  = 3'd2;  // drop pushed value into the root
  localparam logic [2:0] S_PD_LAST = 3'd3;  // last entry arrives from memory
  localparam logic [2:0] S_PD_RD   = 3'd4;  // issue child reads
  localparam logic [2:0] S_PD_CMP  = 3'd5;  // pick larger child, move it up
  localparam logic [2:0] S_DONE    = 3'd6;  // hand result to output register

  // heap memory and its registered read ports
  logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]             raddr_a, raddr_b, waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic                      we;

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic signed [VALUE_W-1:0] x_q, x_d;        // value travelling through the hole
  logic signed [VALUE_W-1:0] top_q;           // mirror of entry zero
  logic [1:0]                status_q, status_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;

  logic                      out_valid_q;
  mhpq_out_t                 out_q;
  logic                      out_load;

  // index arithmetic
  logic [AW-1:0]  parent, gparent, in_parent;
  logic [AW:0]    lchild, rchild, n_ext;
  logic           l_in, r_in;
  logic           pick_l, pick_r;
  logic signed [VALUE_W-1:0] best_val;
  logic           accept;

  assign parent    = AW'((pos_q - AW'(1)) >> 1);
  assign gparent   = AW'((parent - AW'(1)) >> 1);
  assign in_parent = AW'((AW'(cnt_q) - AW'(1)) >> 1);
  assign lchild    = {pos_q, 1'b1};
  assign rchild    = lchild + (AW+1)'(1);
  assign n_ext     = (AW+1)'(cnt_q);
  assign l_in      = lchild < n_ext;
  assign r_in      = rchild < n_ext;

  // ties keep the left child, and the parent over either child
  assign pick_l   = l_in && (rd_a_q > x_q);
  assign best_val = pick_l ? rd_a_q : x_q;
  assign pick_r   = r_in && (rd_b_q > best_val);

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    x_d       = x_q;
    status_d  = status_q;
    removed_d = removed_q;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = x_q;
    raddr_a   = parent;
    raddr_b   = rchild[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d  = ST_OK;
          removed_d = '0;
          if (in_i.payload.mode == MODE_PUSH) begin
            if (cnt_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (cnt_q == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = in_i.payload.value;
              cnt_d   = CW'(1);
              state_d = S_DONE;
            end else begin
              pos_d   = AW'(cnt_q);
              x_d     = in_i.payload.value;
              raddr_a = in_parent;
              cnt_d   = cnt_q + CW'(1);
              state_d = S_PU_CMP;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              removed_d = top_q;
              cnt_d     = cnt_q - CW'(1);
              raddr_a   = AW'(cnt_q - CW'(1));
              state_d   = (cnt_q == CW'(1)) ? S_DONE : S_PD_LAST;
            end
          end
        end
      end

      S_PU_CMP: begin
        we = 1'b1;
        if (x_q > rd_a_q) begin
          wdata   = rd_a_q;
          pos_d   = parent;
          raddr_a = gparent;
          state_d = (parent == '0) ? S_PU_FIN : S_PU_CMP;
        end else begin
          state_d = S_DONE;
        end
      end

      S_PU_FIN: begin
        we      = 1'b1;
        state_d = S_DONE;
      end

      S_PD_LAST: begin
        x_d     = rd_a_q;
        pos_d   = '0;
        state_d = S_PD_RD;
      end

      S_PD_RD: begin
        if (!l_in) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr_a = lchild[AW-1:0];
          raddr_b = rchild[AW-1:0];
          state_d = S_PD_CMP;
        end
      end

      S_PD_CMP: begin
        we = 1'b1;
        if (pick_r) begin
          wdata   = rd_b_q;
          pos_d   = rchild[AW-1:0];
          state_d = S_PD_RD;
        end else if (pick_l) begin
          wdata   = rd_a_q;
          pos_d   = lchild[AW-1:0];
          state_d = S_PD_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // memory: one write port, two registered read ports; no read that the sequencer
  // uses hits the entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd_a_q <= heap_mem[raddr_a];
    rd_b_q <= heap_mem[raddr_b];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    x_q       <= x_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
    if (out_load) begin
      out_q.status        <= status_q;
      out_q.removed_value <= removed_q;
      out_q.top_value     <= (cnt_q == '0) ? -32'sd1 : top_q;
      out_q.count         <= COUNT_W'(cnt_q);
      out_q.is_empty      <= (cnt_q == '0);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// ===== rtl/mhpq_checker.sv =====
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_defines.svh.
`include "max_heap_priority_queue_defines.svh"

module mhpq_checker
  import mhpq_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [1:0]                out_status_i,
  input logic signed [VALUE_W-1:0] out_removed_i,
  input logic signed [VALUE_W-1:0] out_top_i,
  input logic [COUNT_W-1:0]        out_count_i,
  input logic                      out_is_empty_i
);

  // a stalled result holds
  `MHPQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_top_i) && $stable(out_count_i) && $stable(out_status_i))

  // empty flag, count and top agree
  `MHPQ_ASSERT_NOW(a_empty_top, out_valid_i && out_is_empty_i, out_top_i == -32'sd1 && out_count_i == '0)

  // refused pop leaves an empty queue and removes nothing
  `MHPQ_ASSERT_NOW(a_pop_refused, out_valid_i && out_status_i == ST_EMPTY, out_is_empty_i && out_removed_i == '0)

  // refused push means the queue holds values
  `MHPQ_ASSERT_NOW(a_push_refused, out_valid_i && out_status_i == ST_FULL, !out_is_empty_i && out_removed_i == '0)

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.payload.status),
  .out_removed_i  (out_o.payload.removed_value),
  .out_top_i      (out_o.payload.top_value),
  .out_count_i    (out_o.payload.count),
  .out_is_empty_i (out_o.payload.is_empty)
);
